### hdl/mtfd_pkg.sv
package mtfd_pkg;

  localparam int FACE_CAP_DEF = 4096;
  localparam int BUCKETS_DEF  = 4096;
  localparam int NODE_BITS_DEF = 24;
  localparam int REF_BITS_DEF = 8;

  localparam int CFG_W     = 13;
  localparam int KIND_W    = 3;
  localparam int ELEM_W    = 24;
  localparam int NODE_W    = 24;
  localparam int FACE_ID_W = 13;
  localparam int REF_OUT_W = 8;
  localparam int STATUS_W  = 2;
  localparam int CFG_RESET = 4096;

  localparam logic [KIND_W-1:0] KIND_TET   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PRISM = 3'd1;
  localparam logic [KIND_W-1:0] KIND_HEX   = 3'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADKIND = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] elem_kind;
    logic [ELEM_W-1:0] element_number;
    logic [NODE_W-1:0] node_0;
    logic [NODE_W-1:0] node_1;
    logic [NODE_W-1:0] node_2;
    logic [NODE_W-1:0] node_3;
    logic [NODE_W-1:0] node_4;
    logic [NODE_W-1:0] node_5;
  } in_t;

  typedef struct packed {
    logic [FACE_ID_W-1:0] face_id;
    logic [REF_OUT_W-1:0] ref_count;
    logic                 is_new;
    logic [ELEM_W-1:0]    partner_element;
    logic [STATUS_W-1:0]  status;
    logic                 last;
  } out_t;

  // vertex order of each triangle, packed {first, second, third}
  function automatic logic [8:0] tri_sel(input logic [KIND_W-1:0] kind, input logic [1:0] t);
    logic [8:0] r;
    r = 9'd0;
    if (kind == KIND_PRISM) begin
      r = t[0] ? {3'd3, 3'd4, 3'd5} : {3'd2, 3'd1, 3'd0};
    end else begin
      case (t)
        2'd0: r = {3'd2, 3'd1, 3'd0};
        2'd1: r = {3'd0, 3'd1, 3'd3};
        2'd2: r = {3'd1, 3'd2, 3'd3};
        2'd3: r = {3'd2, 3'd0, 3'd3};
        default: r = 9'd0;
      endcase
    end
    return r;
  endfunction

endpackage

### hdl/mesh_triangle_face_dedup.sv
// triangle face dedup over a chained hash table
// input channel in_valid/in_stall/in_data carries one volume element; a
// transfer happens when in_valid is high and in_stall low. a tetrahedron
// gives four results, a prism two, a hexahedron none, any other kind one
// result with status invalid. results leave on out_valid/out_stall/out_data,
// held until the receiver takes them; last marks the final one per element.
// per triangle: a sort step, five serial modulo passes in one shared
// remainder unit on max(NODE_BITS, 2*clog2(BUCKETS+1))-bit dividends, two
// multiplies, the bucket head read, a walk over the chain entries, a store
// on a miss, then the result. the element is held until its last result
// is taken. in_stall is high the whole time.
// bucket_count is written on cfg_valid/cfg_ready/cfg_data, ready always;
// write it only while idle. zero is used as 1, values above BUCKETS as
// BUCKETS.
// after reset the bucket heads are cleared, one per cycle, before the
// first element is taken.
module mesh_triangle_face_dedup #(
  parameter int FACE_CAP  = mtfd_pkg::FACE_CAP_DEF,
  parameter int BUCKETS   = mtfd_pkg::BUCKETS_DEF,
  parameter int NODE_BITS = mtfd_pkg::NODE_BITS_DEF,
  parameter int REF_BITS  = mtfd_pkg::REF_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [mtfd_pkg::CFG_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  mtfd_pkg::in_t              in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output mtfd_pkg::out_t             out_data
);
  import mtfd_pkg::*;

  localparam int NB = NODE_BITS;
  localparam int RB = REF_BITS;
  localparam int HB = $clog2(BUCKETS + 1);
  localparam int BI = $clog2(BUCKETS);
  localparam int FB = $clog2(FACE_CAP + 1);
  localparam int FI = $clog2(FACE_CAP);
  localparam int DW = (NB > 2 * HB) ? NB : 2 * HB;
  localparam int FW = 3 * NB + FB + RB + 2 * ELEM_W;
  localparam int O_E1 = 0;
  localparam int O_E0 = ELEM_W;
  localparam int O_RF = 2 * ELEM_W;
  localparam int O_LK = O_RF + RB;
  localparam int O_K2 = O_LK + FB;
  localparam int O_K1 = O_K2 + NB;
  localparam int O_K0 = O_K1 + NB;
  localparam logic [RB-1:0] REF_MAX = {RB{1'b1}};

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SORT   = 4'd2;
  localparam logic [3:0] S_MSTART = 4'd3;
  localparam logic [3:0] S_MWAIT  = 4'd4;
  localparam logic [3:0] S_MUL    = 4'd5;
  localparam logic [3:0] S_HEAD   = 4'd6;
  localparam logic [3:0] S_HWAIT  = 4'd7;
  localparam logic [3:0] S_WALK   = 4'd8;
  localparam logic [3:0] S_CHK    = 4'd9;
  localparam logic [3:0] S_MISS   = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  logic [3:0]        state;
  logic [CFG_W-1:0]  bucket_count;
  logic [BI-1:0]     clr_addr;
  logic [KIND_W-1:0] kind;
  logic [ELEM_W-1:0] elem;
  logic [NB-1:0]     nodes [6];
  logic [1:0]        tri_idx;
  logic [NB-1:0]     key0, key1, key2;
  logic [HB-1:0]     h_reg, ra, rb, rp, rc;
  logic [2:0]        phase;
  logic [2*HB-1:0]   prod;
  logic [BI-1:0]     bidx;
  logic [FB-1:0]     head, cur, total;
  out_t              outr;

  logic              mod_start, mod_done;
  logic [DW-1:0]     mod_dividend;
  logic [HB-1:0]     mod_rem;
  logic [HB-1:0]     mul_a, mul_b;
  logic [HB-1:0]     h_clamp;
  logic [8:0]        sel;
  logic [NB-1:0]     ta, tb, tc, s0, s1, s2, tmp;
  logic              last_tri;

  logic              b_we;
  logic [BI-1:0]     b_waddr;
  logic [FB-1:0]     b_wdata, b_rdata;
  logic              f_we;
  logic [FI-1:0]     f_waddr;
  logic [FW-1:0]     f_wdata, f_rdata;

  logic [RB-1:0]     f_refs, refs_next;
  logic [ELEM_W-1:0] e1_next;
  logic              match;

  mtfd_mod #(.DW(DW), .HB(HB)) u_mod (
    .clk(clk), .rst(rst), .start(mod_start), .dividend(mod_dividend),
    .divisor(h_reg), .done(mod_done), .rem(mod_rem)
  );

  mtfd_ram #(.W(FB), .D(BUCKETS)) u_heads (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(bidx), .rdata(b_rdata)
  );

  mtfd_ram #(.W(FW), .D(FACE_CAP)) u_faces (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(FI'(cur - FB'(1))), .rdata(f_rdata)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data  = outr;

  always_comb begin
    if (bucket_count == '0) begin
      h_clamp = HB'(1);
    end else if (int'(bucket_count) > BUCKETS) begin
      h_clamp = HB'(BUCKETS);
    end else begin
      h_clamp = HB'(bucket_count);
    end
  end

  // sort the three vertex ids of the current triangle
  always_comb begin
    tmp = '0;
    sel = tri_sel(kind, tri_idx);
    ta = nodes[sel[8:6]];
    tb = nodes[sel[5:3]];
    tc = nodes[sel[2:0]];
    if (ta > tb) begin
      tmp = ta; ta = tb; tb = tmp;
    end
    if (tb > tc) begin
      tmp = tb; tb = tc; tc = tmp;
    end
    if (ta > tb) begin
      tmp = ta; ta = tb; tb = tmp;
    end
    s0 = ta;
    s1 = tb;
    s2 = tc;
  end

  always_comb begin
    case (phase)
      3'd0:    mod_dividend = DW'(key0);
      3'd1:    mod_dividend = DW'(key1);
      3'd3:    mod_dividend = DW'(key2);
      default: mod_dividend = DW'(prod);
    endcase
  end
  assign mod_start = (state == S_MSTART);
  assign mul_a = (phase == 3'd1) ? ra : rc;
  assign mul_b = (phase == 3'd1) ? rb : rp;

  assign last_tri = (kind == KIND_PRISM) ? (tri_idx == 2'd1) : (tri_idx == 2'd3);

  assign f_refs = f_rdata[O_RF +: RB];
  assign match = (f_rdata[O_K0 +: NB] == key0) && (f_rdata[O_K1 +: NB] == key1) &&
                 (f_rdata[O_K2 +: NB] == key2);
  assign refs_next = (f_refs < REF_MAX) ? f_refs + RB'(1) : f_refs;
  assign e1_next = (refs_next == RB'(2)) ? elem : f_rdata[O_E1 +: ELEM_W];

  always_comb begin
    b_we    = 1'b0;
    b_waddr = bidx;
    b_wdata = FB'(total + FB'(1));
    f_we    = 1'b0;
    f_waddr = FI'(cur - FB'(1));
    f_wdata = f_rdata;
    if (state == S_CLR) begin
      b_we    = 1'b1;
      b_waddr = clr_addr;
      b_wdata = '0;
    end else if (state == S_CHK && cur != '0 && match) begin
      f_we    = 1'b1;
      f_wdata = {f_rdata[FW-1:O_RF + RB], refs_next, f_rdata[O_E0 +: ELEM_W], e1_next};
    end else if (state == S_MISS && total < FB'(FACE_CAP)) begin
      b_we    = 1'b1;
      f_we    = 1'b1;
      f_waddr = FI'(total);
      f_wdata = {key0, key1, key2, head, RB'(1), elem, {ELEM_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      clr_addr     <= '0;
      bucket_count <= CFG_W'(CFG_RESET);
      total        <= '0;
      phase        <= '0;
      tri_idx      <= '0;
    end else begin
      if (cfg_valid) begin
        bucket_count <= cfg_data;
      end
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + BI'(1);
          if (clr_addr == BI'(BUCKETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            kind     <= in_data.elem_kind;
            elem     <= in_data.element_number;
            nodes[0] <= NB'(in_data.node_0);
            nodes[1] <= NB'(in_data.node_1);
            nodes[2] <= NB'(in_data.node_2);
            nodes[3] <= NB'(in_data.node_3);
            nodes[4] <= NB'(in_data.node_4);
            nodes[5] <= NB'(in_data.node_5);
            tri_idx  <= '0;
            if (in_data.elem_kind == KIND_TET || in_data.elem_kind == KIND_PRISM) begin
              state <= S_SORT;
            end else if (in_data.elem_kind != KIND_HEX) begin
              outr  <= '{face_id: '0, ref_count: '0, is_new: 1'b0, partner_element: '0,
                         status: ST_BADKIND, last: 1'b1};
              state <= S_OUT;
            end
          end
        end
        S_SORT: begin
          key0  <= s0;
          key1  <= s1;
          key2  <= s2;
          h_reg <= h_clamp;
          phase <= '0;
          state <= S_MSTART;
        end
        S_MSTART: begin
          state <= S_MWAIT;
        end
        S_MWAIT: begin
          if (mod_done) begin
            case (phase)
              3'd0: begin
                ra    <= mod_rem;
                phase <= 3'd1;
                state <= S_MSTART;
              end
              3'd1: begin
                rb    <= mod_rem;
                state <= S_MUL;
              end
              3'd2: begin
                rp    <= mod_rem;
                phase <= 3'd3;
                state <= S_MSTART;
              end
              3'd3: begin
                rc    <= mod_rem;
                state <= S_MUL;
              end
              default: begin
                bidx  <= BI'(mod_rem);
                state <= S_HEAD;
              end
            endcase
          end
        end
        S_MUL: begin
          prod  <= (2 * HB)'(mul_a) * (2 * HB)'(mul_b);
          phase <= phase + 3'd1;
          state <= S_MSTART;
        end
        S_HEAD: begin
          state <= S_HWAIT;
        end
        S_HWAIT: begin
          head  <= b_rdata;
          cur   <= b_rdata;
          state <= S_WALK;
        end
        S_WALK: begin
          state <= (cur == '0) ? S_MISS : S_CHK;
        end
        S_CHK: begin
          if (match) begin
            outr.face_id         <= FACE_ID_W'(cur);
            outr.ref_count       <= REF_OUT_W'(refs_next);
            outr.is_new          <= 1'b0;
            outr.partner_element <= f_rdata[O_E0 +: ELEM_W];
            outr.status          <= ST_OK;
            outr.last            <= last_tri;
            state                <= S_OUT;
          end else begin
            cur   <= f_rdata[O_LK +: FB];
            state <= S_WALK;
          end
        end
        S_MISS: begin
          if (total < FB'(FACE_CAP)) begin
            total <= total + FB'(1);
            outr  <= '{face_id: FACE_ID_W'(total + FB'(1)), ref_count: REF_OUT_W'(1),
                       is_new: 1'b1, partner_element: '0, status: ST_OK, last: last_tri};
          end else begin
            outr  <= '{face_id: '0, ref_count: '0, is_new: 1'b0, partner_element: '0,
                       status: ST_FULL, last: last_tri};
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            if (outr.last) begin
              state <= S_IDLE;
            end else begin
              tri_idx <= tri_idx + 2'd1;
              state   <= S_SORT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_total_cap: assert property (@(posedge clk) disable iff (rst)
    total <= FB'(FACE_CAP)) else $error("face total beyond capacity");

  a_new_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_new |->
      out_data.partner_element == '0 && out_data.status == ST_OK &&
      out_data.face_id != '0) else $error("bad new face result");

  a_bad_kind_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_BADKIND |-> out_data.last)
    else $error("invalid kind result not last");

  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input open while result pending");

  a_total_step: assert property (@(posedge clk) disable iff (rst)
    total != $past(total) |-> $past(state) == S_MISS) else $error("face total moved");
endmodule

### hdl/mtfd_ram.sv
module mtfd_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hdl/mtfd_mod.sv
module mtfd_mod #(
  parameter int DW = 26,
  parameter int HB = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [HB-1:0] divisor,
  output logic          done,
  output logic [HB-1:0] rem
);
  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] dsr;
  logic [HB-1:0] d;
  logic [HB:0]   rem_sh;

  // one dividend bit per cycle, restoring
  assign rem_sh = {rem, dsr[DW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
        dsr  <= dividend;
        d    <= divisor;
        rem  <= '0;
      end else if (busy) begin
        dsr <= dsr << 1;
        rem <= (rem_sh >= {1'b0, d}) ? HB'(rem_sh - {1'b0, d}) : HB'(rem_sh);
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
